[hdl/lrd_pkg.sv]
// ---------------------------------------------------------------------------
// lrd_pkg
// Shared widths, latency figures and beat types of the listener relative
// direction core.
// ---------------------------------------------------------------------------
package lrd_pkg;

  localparam int POS_W    = 32;
  localparam int DIR_W    = 16;
  localparam int CFG_W    = 16;
  localparam int FRAC     = 14;

  localparam int UNIT_W   = FRAC + 2;
  localparam int NORM_MSB = 23;
  localparam int NORM_W   = NORM_MSB + 1;
  localparam int SQ_W     = 2 * NORM_W + 2;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int QUO_W    = FRAC + 1;
  localparam int NUM_W    = NORM_W + FRAC + 1;
  localparam int NORM_LAT = 5 + ROOT_W + 1 + QUO_W + 1;

  localparam int OP_W     = (UNIT_W > DIR_W) ? UNIT_W : DIR_W;
  localparam int PRD_W    = 2 * OP_W;

  localparam logic [CFG_W-1:0] MIN_DIST_RST = CFG_W'(1);
  localparam logic [DIR_W-1:0] UP_DEFAULT =
    (DIR_W - 1 > FRAC) ? DIR_W'(1 << FRAC) : DIR_W'((1 << (DIR_W - 1)) - 1);

  typedef struct packed {
    logic signed [POS_W-1:0] source_x;
    logic signed [POS_W-1:0] source_y;
    logic signed [POS_W-1:0] source_z;
    logic signed [POS_W-1:0] listener_x;
    logic signed [POS_W-1:0] listener_y;
    logic signed [POS_W-1:0] listener_z;
    logic signed [DIR_W-1:0] ahead_x;
    logic signed [DIR_W-1:0] ahead_y;
    logic signed [DIR_W-1:0] ahead_z;
    logic signed [DIR_W-1:0] up_x;
    logic signed [DIR_W-1:0] up_y;
    logic signed [DIR_W-1:0] up_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_right;
    logic signed [DIR_W-1:0] dir_up;
    logic signed [DIR_W-1:0] dir_back;
    logic                    too_close;
  } out_beat_t;

endpackage

[hdl/lrd_norm.sv]
// ---------------------------------------------------------------------------
// lrd_norm
// Pipelined vector normalizer: block scaling, bit-serial square root and
// per-component restoring division to a Q2.14 unit vector.
// ---------------------------------------------------------------------------
module lrd_norm #(
  parameter int IN_W = 33
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [2:0][IN_W-1:0]                vec,
  output logic [2:0][lrd_pkg::UNIT_W-1:0]     unit
);
  import lrd_pkg::*;

  localparam int EW = (IN_W > NORM_W) ? IN_W : NORM_W;
  localparam int PW = $clog2(EW);

  // magnitudes and max
  logic [2:0][IN_W-1:0] mag_c;
  logic [IN_W-1:0]      mx_c;
  logic [2:0][IN_W-1:0] m1_r;
  logic [2:0]           s1_r;
  logic [IN_W-1:0]      mx1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][IN_W-1] ? (~vec[i] + IN_W'(1)) : vec[i];
    end
    mx_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
    if (mag_c[2] > mx_c) begin
      mx_c = mag_c[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= mag_c;
      mx1_r <= mx_c;
      for (int i = 0; i < 3; i++) begin
        s1_r[i] <= vec[i][IN_W-1];
      end
    end
  end

  // leading one
  logic [PW-1:0]        lead_c;
  logic [2:0][IN_W-1:0] m2_r;
  logic [2:0]           s2_r;
  logic [PW-1:0]        lead2_r;
  logic                 z2_r;

  always_comb begin
    lead_c = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (mx1_r[b]) begin
        lead_c = PW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r    <= m1_r;
      s2_r    <= s1_r;
      lead2_r <= lead_c;
      z2_r    <= (mx1_r == '0);
    end
  end

  // block shift so the largest lands in [2^23, 2^24)
  logic [2:0][NORM_W-1:0] m24_c;
  logic [EW-1:0]          ext_c;
  logic [EW-1:0]          sh_c;
  logic [2:0][NORM_W-1:0] m3_r;
  logic [2:0]             s3_r;
  logic                   z3_r;

  always_comb begin
    ext_c = '0;
    sh_c  = '0;
    for (int i = 0; i < 3; i++) begin
      ext_c = EW'(m2_r[i]);
      if (lead2_r > PW'(NORM_MSB)) begin
        sh_c = ext_c >> (lead2_r - PW'(NORM_MSB));
      end else begin
        sh_c = ext_c << (PW'(NORM_MSB) - lead2_r);
      end
      m24_c[i] = sh_c[NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r <= m24_c;
      s3_r <= s2_r;
      z3_r <= z2_r;
    end
  end

  // squares
  logic [2:0][2*NORM_W-1:0] sq4_r;
  logic [2:0][NORM_W-1:0]   m4_r;
  logic [2:0]               s4_r;
  logic                     z4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= (2*NORM_W)'(m3_r[i]) * (2*NORM_W)'(m3_r[i]);
      end
      m4_r <= m3_r;
      s4_r <= s3_r;
      z4_r <= z3_r;
    end
  end

  // square root, one result bit per stage
  logic [SQ_W-1:0]        rad_r  [0:ROOT_W];
  logic [ROOT_W+1:0]      rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]      root_r [0:ROOT_W];
  logic [2:0][NORM_W-1:0] mq_r   [0:ROOT_W];
  logic [2:0]             sq_s_r [0:ROOT_W];
  logic                   sq_z_r [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= SQ_W'(sq4_r[0]) + SQ_W'(sq4_r[1]) + SQ_W'(sq4_r[2]);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      mq_r[0]   <= m4_r;
      sq_s_r[0] <= s4_r;
      sq_z_r[0] <= z4_r;
    end
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    logic [ROOT_W+1:0] rsh_c;
    logic [ROOT_W+1:0] trial_c;

    assign rsh_c   = {rem_r[k-1][ROOT_W-1:0], rad_r[k-1][SQ_W-1 -: 2]};
    assign trial_c = {root_r[k-1], 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_r[k-1] << 2;
        if (rsh_c >= trial_c) begin
          rem_r[k]  <= rsh_c - trial_c;
          root_r[k] <= {root_r[k-1][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rsh_c;
          root_r[k] <= {root_r[k-1][ROOT_W-2:0], 1'b0};
        end
        mq_r[k]   <= mq_r[k-1];
        sq_s_r[k] <= sq_s_r[k-1];
        sq_z_r[k] <= sq_z_r[k-1];
      end
    end
  end

  // division, one quotient bit per stage
  logic [2:0][NUM_W-1:0] rm_r   [0:QUO_W];
  logic [2:0][QUO_W-1:0] q_r    [0:QUO_W];
  logic [ROOT_W-1:0]     dv_r   [0:QUO_W];
  logic [2:0]            dv_s_r [0:QUO_W];
  logic                  dv_z_r [0:QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rm_r[0][i] <= (NUM_W'(mq_r[ROOT_W][i]) << FRAC) + NUM_W'(root_r[ROOT_W] >> 1);
      end
      q_r[0]    <= '0;
      dv_r[0]   <= root_r[ROOT_W];
      dv_s_r[0] <= sq_s_r[ROOT_W];
      dv_z_r[0] <= sq_z_r[ROOT_W];
    end
  end

  for (genvar t = 1; t <= QUO_W; t++) begin : g_div
    localparam int B = QUO_W - t;
    logic [NUM_W-1:0] dsh_c;

    assign dsh_c = NUM_W'(dv_r[t-1]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rm_r[t-1][i] >= dsh_c) begin
            rm_r[t][i]   <= rm_r[t-1][i] - dsh_c;
            q_r[t][i]    <= q_r[t-1][i] | (QUO_W'(1) << B);
          end else begin
            rm_r[t][i]   <= rm_r[t-1][i];
            q_r[t][i]    <= q_r[t-1][i];
          end
        end
        dv_r[t]   <= dv_r[t-1];
        dv_s_r[t] <= dv_s_r[t-1];
        dv_z_r[t] <= dv_z_r[t-1];
      end
    end
  end

  // sign and zero vector
  logic [2:0][UNIT_W-1:0] unit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_z_r[QUO_W]) begin
          unit_r[i] <= '0;
        end else if (dv_s_r[QUO_W][i]) begin
          unit_r[i] <= ~UNIT_W'(q_r[QUO_W][i]) + UNIT_W'(1);
        end else begin
          unit_r[i] <= UNIT_W'(q_r[QUO_W][i]);
        end
      end
    end
  end

  assign unit = unit_r;

endmodule

[hdl/listener_relative_direction_core.sv]
// ---------------------------------------------------------------------------
// listener_relative_direction_core
// Source direction in the listener frame, Q16.16 positions in, Q2.14 out.
// ---------------------------------------------------------------------------
// One beat enters per clock while the result side is not stalled; the latency
// is set by the two normalizers, whose 25-stage square root and 15-stage
// divider dominate the pipeline. A stall on the result side holds the whole
// pipeline and in_ready falls in the same cycle. The config channel is always
// ready and takes min_distance (unsigned Q0.16, reset 1); write it only while
// no beat is in flight.
module listener_relative_direction_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lrd_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lrd_pkg::out_beat_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lrd_pkg::CFG_W-1:0]  cfg_data
);
  import lrd_pkg::*;

  localparam int D_W      = POS_W + 1;
  localparam int C_W      = 2 * DIR_W;
  localparam int NORM_IN  = 2;
  localparam int NORM_OUT = NORM_IN + NORM_LAT;
  localparam int PRD_ST   = NORM_OUT + 1;
  localparam int RND_ST   = PRD_ST + 1;
  localparam int SUM_W    = PRD_W + 2;
  localparam int RND_W    = SUM_W - FRAC;
  localparam int SQS_W    = 2 * CFG_W;

  localparam logic signed [RND_W:0] SAT_HI = (RND_W+1)'((64'sd1 <<< (DIR_W - 1)) - 1);
  localparam logic signed [RND_W:0] SAT_LO = -SAT_HI - (RND_W+1)'(1);

  function automatic logic [C_W-1:0] half_trunc(input logic [C_W-1:0] p);
    logic signed [C_W-1:0] ps;
    ps = $signed(p) + $signed(C_W'(p[C_W-1]));
    return ps >>> 1;
  endfunction

  function automatic logic [DIR_W-1:0] sat_dir(input logic signed [RND_W:0] x);
    logic [DIR_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[DIR_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[DIR_W-1:0];
    end else begin
      r = x[DIR_W-1:0];
    end
    return r;
  endfunction

  logic             en;
  logic [RND_ST:1]  v_r;
  logic             out_valid_r;
  logic [CFG_W-1:0] min_dist_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RST;
    end else if (cfg_valid) begin
      min_dist_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[RND_ST-1:1], in_valid};
      out_valid_r <= v_r[RND_ST];
    end
  end

  // stage 1: offsets and cross products
  logic [2:0][POS_W-1:0]     src_c, lis_c;
  logic [2:0][DIR_W-1:0]     ah_c, up_c;
  logic signed [C_W-1:0]     ahx_c [3];
  logic signed [C_W-1:0]     upx_c [3];
  logic [2:0][D_W-1:0]       d1_r;
  logic [5:0][C_W-1:0]       prod1_r;
  logic [2:0][DIR_W-1:0]     ah_r [1:NORM_OUT];
  logic [2:0][DIR_W-1:0]     up_r [1:NORM_OUT];

  assign src_c = {in_data.source_z, in_data.source_y, in_data.source_x};
  assign lis_c = {in_data.listener_z, in_data.listener_y, in_data.listener_x};
  assign ah_c  = {in_data.ahead_z, in_data.ahead_y, in_data.ahead_x};
  assign up_c  = {in_data.up_z, in_data.up_y, in_data.up_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ahx_c[i] = C_W'($signed(ah_c[i]));
      upx_c[i] = C_W'($signed(up_c[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= D_W'($signed(src_c[i])) - D_W'($signed(lis_c[i]));
      end
      prod1_r[0] <= ahx_c[1] * upx_c[2];
      prod1_r[1] <= ahx_c[2] * upx_c[1];
      prod1_r[2] <= ahx_c[2] * upx_c[0];
      prod1_r[3] <= ahx_c[0] * upx_c[2];
      prod1_r[4] <= ahx_c[0] * upx_c[1];
      prod1_r[5] <= ahx_c[1] * upx_c[0];
      ah_r[1]    <= ah_c;
      up_r[1]    <= up_c;
      for (int k = 2; k <= NORM_OUT; k++) begin
        ah_r[k] <= ah_r[k-1];
        up_r[k] <= up_r[k-1];
      end
    end
  end

  // stage 2: cross, offset magnitudes, near-field squares
  logic [2:0][D_W-1:0]   dm_c;
  logic [2:0][SQS_W-1:0] dsm_c;
  logic                  gt_c;
  logic [2:0][D_W-1:0]   d2_r;
  logic [2:0][C_W-1:0]   cr2_r;
  logic [2:0][SQS_W-1:0] sq2_r;
  logic [SQS_W-1:0]      minsq2_r;
  logic                  gt2_r;

  always_comb begin
    gt_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dm_c[i]  = d1_r[i][D_W-1] ? (~d1_r[i] + D_W'(1)) : d1_r[i];
      dsm_c[i] = SQS_W'(dm_c[i][CFG_W-1:0]);
      if (dm_c[i] > D_W'(min_dist_r)) begin
        gt_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r     <= d1_r;
      cr2_r[0] <= half_trunc(prod1_r[0]) - half_trunc(prod1_r[1]);
      cr2_r[1] <= half_trunc(prod1_r[2]) - half_trunc(prod1_r[3]);
      cr2_r[2] <= half_trunc(prod1_r[4]) - half_trunc(prod1_r[5]);
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= dsm_c[i] * dsm_c[i];
      end
      minsq2_r <= SQS_W'(min_dist_r) * SQS_W'(min_dist_r);
      gt2_r    <= gt_c;
    end
  end

  // stage 3 onward: far flag rides alongside the normalizers
  logic [RND_ST:3] far_r;

  always_ff @(posedge clk) begin
    if (en) begin
      far_r[3] <= gt2_r ||
                  ((SQS_W+2)'(sq2_r[0]) + (SQS_W+2)'(sq2_r[1]) + (SQS_W+2)'(sq2_r[2]) >
                   (SQS_W+2)'(minsq2_r));
      far_r[RND_ST:4] <= far_r[RND_ST-1:3];
    end
  end

  logic [2:0][UNIT_W-1:0] ud_c;
  logic [2:0][UNIT_W-1:0] ur_c;

  lrd_norm #(.IN_W(D_W)) u_norm_off (
    .clk  (clk),
    .en   (en),
    .vec  (d2_r),
    .unit (ud_c)
  );

  lrd_norm #(.IN_W(C_W)) u_norm_right (
    .clk  (clk),
    .en   (en),
    .vec  (cr2_r),
    .unit (ur_c)
  );

  // dot products
  logic [2:0][PRD_W-1:0] pr_rt_r, pr_up_r, pr_ah_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_rt_r[i] <= $signed(PRD_W'($signed(ud_c[i]))) * $signed(PRD_W'($signed(ur_c[i])));
        pr_up_r[i] <= $signed(PRD_W'($signed(ud_c[i]))) *
                      $signed(PRD_W'($signed(up_r[NORM_OUT][i])));
        pr_ah_r[i] <= $signed(PRD_W'($signed(ud_c[i]))) *
                      $signed(PRD_W'($signed(ah_r[NORM_OUT][i])));
      end
    end
  end

  // round to q14
  logic [SUM_W-1:0]      srt_c, sup_c, sah_c;
  logic [2:0][RND_W-1:0] rnd_r;

  assign srt_c = SUM_W'($signed(pr_rt_r[0])) + SUM_W'($signed(pr_rt_r[1])) +
                 SUM_W'($signed(pr_rt_r[2])) + SUM_W'(1 << (FRAC - 1));
  assign sup_c = SUM_W'($signed(pr_up_r[0])) + SUM_W'($signed(pr_up_r[1])) +
                 SUM_W'($signed(pr_up_r[2])) + SUM_W'(1 << (FRAC - 1));
  assign sah_c = SUM_W'($signed(pr_ah_r[0])) + SUM_W'($signed(pr_ah_r[1])) +
                 SUM_W'($signed(pr_ah_r[2])) + SUM_W'(1 << (FRAC - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r[0] <= srt_c[SUM_W-1:FRAC];
      rnd_r[1] <= sup_c[SUM_W-1:FRAC];
      rnd_r[2] <= sah_c[SUM_W-1:FRAC];
    end
  end

  // saturate and select the default direction
  out_beat_t out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (far_r[RND_ST]) begin
        out_r.dir_right <= sat_dir((RND_W+1)'($signed(rnd_r[0])));
        out_r.dir_up    <= sat_dir((RND_W+1)'($signed(rnd_r[1])));
        out_r.dir_back  <= sat_dir(-((RND_W+1)'($signed(rnd_r[2]))));
        out_r.too_close <= 1'b0;
      end else begin
        out_r.dir_right <= '0;
        out_r.dir_up    <= UP_DEFAULT;
        out_r.dir_back  <= '0;
        out_r.too_close <= 1'b1;
      end
    end
  end

  assign out_data = out_r;

  a_close_default: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.too_close |->
      out_data.dir_right == '0 && out_data.dir_back == '0 && out_data.dir_up == UP_DEFAULT)
    else $error("too_close beat without default direction");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r) && $stable(out_valid_r))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[1])
    else $error("accepted beat missing from first stage");

  a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[RND_ST] |=> out_valid)
    else $error("last stage beat lost");

endmodule

[verif/tb_listener_relative_direction_core.sv]
// ---------------------------------------------------------------------------
// tb_listener_relative_direction_core
// Drives position and axis beats under random idling and checks every result
// beat field by field against an in-bench fixed-point predictor of the
// listener-frame direction, over several min_distance settings.
// ---------------------------------------------------------------------------
module tb_listener_relative_direction_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lrd_pkg::*;

  class direction_scoreboard;
    out_beat_t expected_dirs[$];
    longint    min_dist = 1;
    int        errors = 0;

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
    endfunction

    function automatic void to_unit(input longint v[3], output longint u[3]);
      longint unsigned m[3];
      longint unsigned mx, acc, len, q;
      mx = 0;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = abs64(v[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        u = '{0, 0, 0};
        return;
      end
      while (mx >= (64'd1 << 24)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 23)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) acc += m[i] * m[i];
      len = int_sqrt(acc);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << FRAC) + (len >> 1)) / len;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    endfunction

    function automatic longint round_half_up(longint x);
      longint n, d;
      n = x + (64'sd1 << (FRAC - 1));
      d = 64'sd1 << FRAC;
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
    endfunction

    function automatic logic [DIR_W-1:0] clamp_dir(longint x);
      longint hi, lo;
      hi = (64'sd1 << (DIR_W - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) x = hi;
      if (x < lo) x = lo;
      return x[DIR_W-1:0];
    endfunction

    function automatic longint dot3(longint a[3], longint b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic out_beat_t listener_dir(in_beat_t b);
      longint d[3], ah[3], up[3], cr[3], rt[3], u[3];
      longint mx, s;
      logic far;
      out_beat_t r;
      d[0] = longint'(b.source_x) - longint'(b.listener_x);
      d[1] = longint'(b.source_y) - longint'(b.listener_y);
      d[2] = longint'(b.source_z) - longint'(b.listener_z);
      ah = '{longint'(b.ahead_x), longint'(b.ahead_y), longint'(b.ahead_z)};
      up = '{longint'(b.up_x), longint'(b.up_y), longint'(b.up_z)};
      mx = 0;
      for (int i = 0; i < 3; i++) if (abs64(d[i]) > mx) mx = abs64(d[i]);
      cr[0] = (ah[1] * up[2]) / 2 - (ah[2] * up[1]) / 2;
      cr[1] = (ah[2] * up[0]) / 2 - (ah[0] * up[2]) / 2;
      cr[2] = (ah[0] * up[1]) / 2 - (ah[1] * up[0]) / 2;
      to_unit(cr, rt);
      if (mx > min_dist) begin
        far = 1'b1;
      end else begin
        s = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        far = s > min_dist * min_dist;
      end
      if (!far) begin
        r.dir_right = '0;
        r.dir_up    = clamp_dir(64'sd1 << FRAC);
        r.dir_back  = '0;
        r.too_close = 1'b1;
        return r;
      end
      to_unit(d, u);
      r.dir_right = clamp_dir(round_half_up(dot3(u, rt)));
      r.dir_up    = clamp_dir(round_half_up(dot3(u, up)));
      r.dir_back  = clamp_dir(-round_half_up(dot3(u, ah)));
      r.too_close = 1'b0;
      return r;
    endfunction

    function void note_input(in_beat_t b);
      expected_dirs.push_back(listener_dir(b));
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp_b;
      if (expected_dirs.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      exp_b = expected_dirs.pop_front();
      if (got.dir_right !== exp_b.dir_right) begin
        $display("%0t: dir_right exp %h got %h", $time, exp_b.dir_right, got.dir_right);
        errors++;
      end
      if (got.dir_up !== exp_b.dir_up) begin
        $display("%0t: dir_up exp %h got %h", $time, exp_b.dir_up, got.dir_up);
        errors++;
      end
      if (got.dir_back !== exp_b.dir_back) begin
        $display("%0t: dir_back exp %h got %h", $time, exp_b.dir_back, got.dir_back);
        errors++;
      end
      if (got.too_close !== exp_b.too_close) begin
        $display("%0t: too_close exp %b got %b", $time, exp_b.too_close, got.too_close);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  direction_scoreboard sb = new();
  int send_idle_pct = 29;
  int recv_idle_pct = 65;
  longint cycles = 0;

  listener_relative_direction_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_listener_relative_direction_core failed");
      $finish;
    end
  end

  // beat monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_beat(in_beat_t b);
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_dirs.size() != 0) @(posedge clk);
  endtask

  task automatic write_min_dist(logic [CFG_W-1:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.min_dist = longint'(v);
  endtask

  function automatic in_beat_t mk(longint sx, longint sy, longint sz, longint lx,
                                  longint ly, longint lz, int ax, int ay, int az,
                                  int ux, int uy, int uz);
    in_beat_t b;
    b.source_x = POS_W'(sx); b.source_y = POS_W'(sy); b.source_z = POS_W'(sz);
    b.listener_x = POS_W'(lx); b.listener_y = POS_W'(ly); b.listener_z = POS_W'(lz);
    b.ahead_x = DIR_W'(ax); b.ahead_y = DIR_W'(ay); b.ahead_z = DIR_W'(az);
    b.up_x = DIR_W'(ux); b.up_y = DIR_W'(uy); b.up_z = DIR_W'(uz);
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int off[3];
    b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      0: off = '{0, 0, 0};
      1: for (int i = 0; i < 3; i++) off[i] = int'($urandom_range(0, 140000)) - 70000;
      2: for (int i = 0; i < 3; i++) off[i] = int'($urandom_range(0, 4)) - 2;
      default: off = '{$urandom, $urandom, $urandom};
    endcase
    if ($urandom_range(0, 3) != 0) begin
      b.source_x = POS_W'(b.listener_x + off[0]);
      b.source_y = POS_W'(b.listener_y + off[1]);
      b.source_z = POS_W'(b.listener_z + off[2]);
    end
    case ($urandom_range(0, 5))
      0: begin
        b.up_x = b.ahead_x; b.up_y = b.ahead_y; b.up_z = b.ahead_z;
      end
      1: begin
        b.up_x = -b.ahead_x; b.up_y = -b.ahead_y; b.up_z = -b.ahead_z;
      end
      2: begin
        b.ahead_x = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        b.ahead_y = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        b.ahead_z = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        b.up_x = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        b.up_y = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        b.up_z = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic random_run(int n);
    repeat (n) send_beat(random_beat());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at the reset threshold
    send_beat(mk(0, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
    send_beat(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h80000000, 0, 0, 16384, 0, 16384, 0));
    send_beat(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 16384, 0, 0, 0, 0, 16384));
    send_beat(mk(1, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
    send_beat(mk(1, 1, 0, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
    send_beat(mk(0, -2, 0, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
    send_beat(mk(100, 200, -300, 0, 0, 0, 5000, 5000, 5000, 5000, 5000, 5000));
    send_beat(mk(100, 200, -300, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(mk(100, 200, -300, 0, 0, 0, -32768, -32768, -32768, -32768, 32767, -32768));
    send_beat(mk(-1 <<< 20, 1 <<< 20, 1 <<< 20, 0, 0, 0, 32767, 32767, 32767,
                 -32768, -32768, -32768));
    send_beat(mk(1 <<< 20, 1 <<< 20, 1 <<< 20, 0, 0, 0, 32767, -32768, 32767,
                 -32768, 32767, -32768));
    send_beat(mk(0, 0, 5 <<< 16, 0, 0, 0, 0, 0, -16384, 0, 16384, 0));
    send_beat(mk(7, 3, -9, 7, 3, -9, -16384, 0, 0, 0, 0, -16384));

    // sender holds off until the pipe is empty
    drain();
    send_idle_pct = 29;
    recv_idle_pct = 65;
    write_min_dist(16'hffff);
    send_beat(mk(65535, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
    send_beat(mk(65536, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
    send_beat(mk(46341, 46341, 0, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
    send_beat(mk(46340, 46340, 0, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
    random_run(350);
    write_min_dist(16'h0000);
    send_beat(mk(5, 5, 5, 5, 5, 5, 0, 0, 16384, 0, 16384, 0));
    random_run(350);

    send_idle_pct = 65;
    recv_idle_pct = 29;
    write_min_dist(16'($urandom));
    random_run(330);
    write_min_dist(16'd1);
    random_run(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_min_dist(16'($urandom_range(0, 300)));
    random_run(330);
    write_min_dist(16'($urandom));
    random_run(330);

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_listener_relative_direction_core passed");
    end else begin
      $display("tb_listener_relative_direction_core failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lrd_pkg.sv
hdl/lrd_norm.sv
hdl/listener_relative_direction_core.sv
verif/tb_listener_relative_direction_core.sv
